// ===== hw/rtl/sfir_pkg.sv =====
// sfir_pkg: shared types, constants and arithmetic helpers for the separable fir
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package sfir_pkg;
   localparam int MAX_TAPS = 8;
   localparam int MAX_WIDTH = 1024;
   localparam int HIST = MAX_TAPS - 1;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = 11;
   localparam int TW = 4;
   localparam int TAPW = $clog2(MAX_TAPS + 1);

   localparam logic [2:0] REG_WIDTH    = 3'd0;
   localparam logic [2:0] REG_ROW_TAPS = 3'd1;
   localparam logic [2:0] REG_COL_TAPS = 3'd2;
   localparam logic [2:0] REG_ADD_MODE = 3'd3;
   localparam logic [2:0] REG_ROW_LO   = 3'd4;
   localparam logic [2:0] REG_ROW_HI   = 3'd5;
   localparam logic [2:0] REG_COL_LO   = 3'd6;
   localparam logic [2:0] REG_COL_HI   = 3'd7;

   typedef logic signed [15:0] sample_type;
   typedef logic signed [23:0] rowval_type;

   // product sums: 16x16 taps summed over 8 -> 35 bits; 24x16 over 8 -> 43 bits
   localparam int RSW = 36;
   localparam int CSW = 44;

   typedef struct packed {
      logic          hit;       // sum is valid for the column stage
      logic [XW-1:0] x;
      logic          emit;
      logic          row_end;
      logic signed [31:0] addend;
   } ctl_type;

   function automatic logic signed [15:0] tap_of(input logic [63:0] lo,
                                                 input logic [63:0] hi,
                                                 input int i);
      logic signed [15:0] t;
      t = '0;
      if (i < 4) t = lo[16*i +: 16];
      else if (i < 8) t = hi[16*(i-4) +: 16];
      return t;
   endfunction

   function automatic rowval_type round_row(input logic signed [RSW-1:0] s);
      logic signed [RSW-1:0] t;
      logic signed [RSW-14:0] q;
      t = s + RSW'(4096);
      q = t[RSW-1:13];
      if (q > 24'sh7fffff) return 24'sh7fffff;
      if (q < -24'sh800000) return 24'sh800000;
      return rowval_type'(q);
   endfunction

   // a full column sum fits 31 bits after the shift, so it never reaches the s32 limits
   function automatic logic signed [31:0] round_col(input logic signed [CSW-1:0] s);
      logic signed [CSW-1:0] t;
      logic signed [CSW-14:0] q;
      t = s + CSW'(4096);
      q = t[CSW-1:13];
      return 32'(q);
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/separable_2d_fir_filter.sv =====
// separable_2d_fir_filter: top level, row and column cells of tap products
// depends on sfir_pkg, sfir_mac_cell
//
// channel  dir  ports
// req      in   req_valid req_stall req_sample req_frame_start req_addend
// rsp      out  rsp_valid rsp_stall rsp_filtered_value rsp_row_end
// csr      in   csr_write csr_index csr_data
//
// one item per cycle while no result is stalled; an item that yields a result has it valid after the stages below
// stages: row products, row sum and store read, column products and store write, column sum
// the line store holds one word of seven row values per column, one column per item
// a stalled result holds the whole pipeline and the input
// reset clears positions, the sample window and valid flags, and sets the registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
module separable_2d_fir_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [15:0] req_sample,
   input  wire logic        req_frame_start,
   input  wire logic signed [31:0] req_addend,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_filtered_value,
   output logic             rsp_row_end,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import sfir_pkg::*;

   logic [CW-1:0] width_ff;
   logic [TW-1:0] rtaps_ff, ctaps_ff;
   logic add_ff;
   logic [63:0] rlo_ff, rhi_ff, clo_ff, chi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CW'(1024);
         rtaps_ff <= TW'(1);
         ctaps_ff <= TW'(1);
         add_ff <= 1'b0;
         rlo_ff <= '0; rhi_ff <= '0; clo_ff <= '0; chi_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH:    width_ff <= csr_data[CW-1:0];
            REG_ROW_TAPS: rtaps_ff <= csr_data[TW-1:0];
            REG_COL_TAPS: ctaps_ff <= csr_data[TW-1:0];
            REG_ADD_MODE: add_ff <= csr_data[0];
            REG_ROW_LO:   rlo_ff <= csr_data;
            REG_ROW_HI:   rhi_ff <= csr_data;
            REG_COL_LO:   clo_ff <= csr_data;
            REG_COL_HI:   chi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [CW-1:0] w;
   logic [TAPW-1:0] rs, cs;
   always_comb begin
      w = (width_ff == '0) ? CW'(1) : (width_ff > CW'(MAX_WIDTH) ? CW'(MAX_WIDTH) : width_ff);
      rs = (rtaps_ff == '0) ? TAPW'(1)
         : (rtaps_ff > TW'(MAX_TAPS) ? TAPW'(MAX_TAPS) : TAPW'(rtaps_ff));
      cs = (ctaps_ff == '0) ? TAPW'(1)
         : (ctaps_ff > TW'(MAX_TAPS) ? TAPW'(MAX_TAPS) : TAPW'(ctaps_ff));
   end

   // pipeline: s0 accept, row products -> s1 row sum, store read
   //   -> s2 row round, column products, store write -> s3 column sum -> s4 out
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   assign adv = !(v4_ff && rsp_stall);
   assign req_stall = !adv;
   logic acc;
   assign acc = req_valid && adv;

   logic [CW-1:0] col_ff;
   logic [15:0] row_ff;
   logic [CW-1:0] c;
   logic [15:0] r;
   always_comb begin
      c = col_ff; r = row_ff;
      if (req_frame_start) begin
         c = '0; r = '0;
      end else if (col_ff >= w) begin
         c = '0;
         if (row_ff != 16'hffff) r = row_ff + 16'd1;
      end
   end

   // sample window: entry k holds the sample k+1 items back
   logic signed [15:0] win_ff [HIST];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST; k++) win_ff[k] <= '0;
      end else if (acc) begin
         win_ff[0] <= req_sample;
         for (int k = 1; k < HIST; k++) win_ff[k] <= win_ff[k-1];
      end
   end

   // row stage: cell g holds the product of the sample g items back (the current one for g 0) and tap rs-1-g
   logic signed [CSW-1:0] rprod [MAX_TAPS];
   genvar g;
   generate
      for (g = 0; g < MAX_TAPS; g++) begin : g_row
         logic signed [23:0] d;
         logic signed [15:0] rt;
         logic on;
         assign d = (g == 0) ? rowval_type'(req_sample)
                             : rowval_type'(win_ff[(g == 0) ? 0 : g-1]);
         assign on = TAPW'(g) < rs;
         assign rt = on ? tap_of(rlo_ff, rhi_ff, int'(rs) - 1 - g) : 16'sd0;
         sfir_mac_cell u_cell (
            .clock(clock), .enable(acc), .active(on), .data(d), .tap(rt),
            .sum_prev(CSW'(0)), .sum_out(rprod[g]));
      end
   endgenerate
   logic signed [CSW-1:0] rtotal;
   always_comb begin
      rtotal = '0;
      for (int k = 0; k < MAX_TAPS; k++) rtotal = rtotal + rprod[k];
   end

   ctl_type c1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= acc;
         if (acc) begin
            if (c + CW'(1) >= w) begin
               col_ff <= '0;
               if (r != 16'hffff) row_ff <= r + 16'd1;
               else row_ff <= r;
            end else begin
               col_ff <= c + CW'(1);
               row_ff <= r;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv && acc) begin
         c1_ff.hit <= (c + CW'(1) >= CW'(rs));
         c1_ff.x <= XW'(c + CW'(1) - CW'(rs));
         c1_ff.emit <= (c + CW'(1) >= CW'(rs)) && ({1'b0, r} + 17'd1 >= 17'(cs));
         c1_ff.row_end <= (c + CW'(1) == w);
         c1_ff.addend <= req_addend;
      end
   end

   // line store: one 7-row word per column, read at s1, written at s2
   logic [HIST*24-1:0] mem [MAX_WIDTH];
   logic [HIST*24-1:0] rd_ff;
   ctl_type c2_ff;
   rowval_type r2_ff;
   logic fwd_ff;
   logic [HIST*24-1:0] fwd_word_ff;
   logic [HIST*24-1:0] word2;
   always_ff @(posedge clock) begin
      if (adv && v1_ff && c1_ff.hit) rd_ff <= mem[c1_ff.x];
      if (adv) begin
         c2_ff <= c1_ff;
         r2_ff <= round_row(rtotal[RSW-1:0]);
         fwd_ff <= v2_ff && c2_ff.hit && (c2_ff.x == c1_ff.x);
         fwd_word_ff <= {word2[(HIST-1)*24-1:0], r2_ff};
      end
   end
   assign word2 = fwd_ff ? fwd_word_ff : rd_ff;
   always_ff @(posedge clock) begin
      if (adv && v2_ff && c2_ff.hit) mem[c2_ff.x] <= {word2[(HIST-1)*24-1:0], r2_ff};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && c2_ff.emit;
         v4_ff <= v3_ff;
      end
   end

   // column stage: a row of cells, each tap on one row value, the current one or a stored one
   logic signed [CSW-1:0] prod [MAX_TAPS];
   generate
      for (g = 0; g < MAX_TAPS; g++) begin : g_col
         logic signed [23:0] d;
         logic signed [15:0] ct;
         logic on;
         // col[k] = r for k==0 else line k-1; tap index cs-1-k
         assign d = (g == 0) ? r2_ff : word2[(g == 0 ? 0 : g-1)*24 +: 24];
         assign on = TAPW'(g) < cs;
         assign ct = on ? tap_of(clo_ff, chi_ff, int'(cs) - 1 - g) : 16'sd0;
         sfir_mac_cell u_cell (
            .clock(clock), .enable(adv), .active(on), .data(d), .tap(ct),
            .sum_prev(CSW'(0)), .sum_out(prod[g]));
      end
   endgenerate
   ctl_type c3_ff;
   always_ff @(posedge clock) begin
      if (adv) c3_ff <= c2_ff;
   end

   logic signed [CSW-1:0] csum;
   logic signed [31:0] vcol;
   logic signed [32:0] vadd;
   always_comb begin
      csum = '0;
      for (int k = 0; k < MAX_TAPS; k++) csum = csum + prod[k];
      vcol = round_col(csum);
      vadd = 33'(vcol) + 33'(c3_ff.addend);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (!add_ff) rsp_filtered_value <= vcol;
         else if (vadd[32] != vadd[31]) rsp_filtered_value <= vadd[32] ? 32'sh80000000 : 32'sh7fffffff;
         else rsp_filtered_value <= vadd[31:0];
         rsp_row_end <= c3_ff.row_end;
      end
   end
   assign rsp_valid = v4_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_value))
      else $error("result changed under stall");
   a_nostall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall) else $error("stall without pending result");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !v3_ff |=> !rsp_valid) else $error("result out of nothing");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/sfir_mac_cell.sv =====
// sfir_mac_cell: one tap cell, registers its product added to an incoming sum
// depends on sfir_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfir_mac_cell (
   input  wire logic                            clock,
   input  wire logic                            enable,
   input  wire logic                            active,
   input  wire logic signed [23:0]              data,
   input  wire logic signed [15:0]              tap,
   input  wire logic signed [sfir_pkg::CSW-1:0] sum_prev,
   output logic signed [sfir_pkg::CSW-1:0]      sum_out
);
   import sfir_pkg::*;

   logic signed [39:0] product;
   logic signed [CSW-1:0] sum_ff;
   logic signed [CSW-1:0] sum_in;
   assign product = 40'(data) * 40'(tap);
   assign sum_in = active ? sum_prev + CSW'(product) : sum_prev;
   always_ff @(posedge clock) begin
      if (enable) sum_ff <= sum_in;
   end
   assign sum_out = sum_ff;
endmodule
`default_nettype wire

// ===== bench/separable_2d_fir_filter_test.sv =====
// separable_2d_fir_filter_test: self-checking bench for the separable 2d fir filter
// depends on sfir_pkg and the separable_2d_fir_filter rtl
// a scoreboard class predicts each result from accepted items; tasks drive the ports
`timescale 1ns / 1ps

typedef struct {
   logic signed [31:0] value;
   bit                 row_end;
} fir_result_type;

class fir_scoreboard;
   logic [10:0] width_reg;
   logic [3:0]  row_taps_reg, col_taps_reg;
   bit          add_reg;
   logic [63:0] row_lo, row_hi, col_lo, col_hi;
   logic signed [15:0] win[7];
   logic signed [23:0] lines[7][1024];
   bit          written[7][1024];
   int          col_pos, row_pos;
   fir_result_type expected_q[$];
   int          mismatches, checked;

   function new();
      width_reg = 1024; row_taps_reg = 1; col_taps_reg = 1; add_reg = 0;
      row_lo = 0; row_hi = 0; col_lo = 0; col_hi = 0;
      foreach (win[i]) win[i] = 0;
      col_pos = 0; row_pos = 0; mismatches = 0; checked = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
         sfir_pkg::REG_WIDTH:    width_reg = d[10:0];
         sfir_pkg::REG_ROW_TAPS: row_taps_reg = d[3:0];
         sfir_pkg::REG_COL_TAPS: col_taps_reg = d[3:0];
         sfir_pkg::REG_ADD_MODE: add_reg = d[0];
         sfir_pkg::REG_ROW_LO:   row_lo = d;
         sfir_pkg::REG_ROW_HI:   row_hi = d;
         sfir_pkg::REG_COL_LO:   col_lo = d;
         sfir_pkg::REG_COL_HI:   col_hi = d;
         default: ;
      endcase
   endfunction

   function int clamp(int v, int hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
   endfunction

   function longint coef(logic [63:0] lo, logic [63:0] hi, int i);
      logic signed [15:0] t;
      if (i < 4) t = lo[16*i +: 16];
      else t = hi[16*(i-4) +: 16];
      return t;
   endfunction

   function longint round_sat(longint s, longint lo, longint hi);
      longint q;
      q = (s + 4096) >>> 13;
      return q < lo ? lo : (q > hi ? hi : q);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // false when the next item without a frame start would use a line entry never filled
   function bit can_continue();
      int w, rs, cs, c, r;
      w = clamp(width_reg, 1024); rs = clamp(row_taps_reg, 8); cs = clamp(col_taps_reg, 8);
      c = col_pos; r = row_pos;
      if (c >= w) begin
         c = 0;
         if (r < 65535) r++;
      end
      if (c + 1 >= rs && r + 1 >= cs)
         for (int i = 1; i < cs; i++)
            if (!written[i-1][c+1-rs]) return 0;
      return 1;
   endfunction

   function void note_item(logic signed [15:0] smp, bit fs, logic signed [31:0] addend);
      int w, rs, cs, c, x;
      longint sum, r, v;
      longint cur[8];
      longint col[8];
      fir_result_type e;
      w = clamp(width_reg, 1024); rs = clamp(row_taps_reg, 8); cs = clamp(col_taps_reg, 8);
      if (fs) begin
         col_pos = 0; row_pos = 0;
      end else if (col_pos >= w) begin
         col_pos = 0;
         if (row_pos < 65535) row_pos++;
      end
      c = col_pos;
      cur[0] = smp;
      for (int i = 1; i < 8; i++) cur[i] = win[i-1];
      if (c + 1 >= rs) begin
         x = c + 1 - rs;
         sum = 0;
         for (int i = 0; i < rs; i++) sum += cur[rs-1-i] * coef(row_lo, row_hi, i);
         r = round_sat(sum, -64'sd8388608, 64'sd8388607);
         col[0] = r;
         for (int i = 1; i < 8; i++) col[i] = lines[i-1][x];
         if (row_pos + 1 >= cs) begin
            sum = 0;
            for (int i = 0; i < cs; i++) sum += col[cs-1-i] * coef(col_lo, col_hi, i);
            v = round_sat(sum, -64'sd2147483648, 64'sd2147483647);
            if (add_reg) begin
               v = v + longint'(addend);
               if (v > 64'sd2147483647) v = 64'sd2147483647;
               if (v < -64'sd2147483648) v = -64'sd2147483648;
            end
            e.value = v[31:0];
            e.row_end = (c + 1 == w);
            expected_q.push_back(e);
         end
         for (int i = 6; i > 0; i--) begin
            lines[i][x] = lines[i-1][x];
            written[i][x] = written[i-1][x];
         end
         lines[0][x] = r[23:0];
         written[0][x] = 1;
      end
      for (int i = 6; i > 0; i--) win[i] = win[i-1];
      win[0] = smp;
      if (c + 1 >= w) begin
         col_pos = 0;
         if (row_pos < 65535) row_pos++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function void check_result(logic signed [31:0] value, bit row_end);
      fir_result_type e;
      checked++;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: value %0d row_end %0b", value, row_end);
         return;
      end
      e = expected_q.pop_front();
      if (value !== e.value || row_end !== e.row_end) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected value %0d row_end %0b, got value %0d row_end %0b",
                     e.value, e.row_end, value, row_end);
      end
   endfunction
endclass

module separable_2d_fir_filter_test;
   import sfir_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_sample = 0;
   logic req_frame_start = 0;
   logic signed [31:0] req_addend = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_filtered_value;
   logic rsp_row_end;
   logic csr_write = 0;
   logic [2:0] csr_index = REG_WIDTH;
   logic [63:0] csr_data = 0;

   fir_scoreboard sb = new();
   bit quiet = 0;
   bit long_hold = 0;
   int cycles = 0;
   int items_sent = 0;
   int phases = 0;

   separable_2d_fir_filter i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("separable_2d_fir_filter_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_filtered_value, rsp_row_end);

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] d);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write <= 0;
      sb.set_reg(idx, d);
   endtask

   task automatic wait_idle();
      while (sb.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic send_item(logic signed [15:0] smp, bit fs, logic signed [31:0] addend);
      if (!quiet && !long_hold && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= smp;
      req_frame_start <= fs;
      req_addend <= addend;
      do @(posedge clock); while (req_stall);
      sb.note_item(smp, fs, addend);
      items_sent++;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_addend();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_coefs();
      case ($urandom_range(0, 5))
         0: return 64'h7fff_7fff_7fff_7fff;
         1: return 64'h8000_8000_8000_8000;
         2: return 64'h0000_0000_0000_2000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_phase(logic [10:0] w, logic [3:0] rs, logic [3:0] cs, bit addm,
                            int n, bit fresh);
      bit fs;
      wait_idle();
      write_reg(REG_WIDTH, w);
      write_reg(REG_ROW_TAPS, rs);
      write_reg(REG_COL_TAPS, cs);
      write_reg(REG_ADD_MODE, addm);
      write_reg(REG_ROW_LO, pick_coefs());
      write_reg(REG_ROW_HI, pick_coefs());
      write_reg(REG_COL_LO, pick_coefs());
      write_reg(REG_COL_HI, pick_coefs());
      phases++;
      for (int k = 0; k < n; k++) begin
         fs = (k == 0 && fresh) || !sb.can_continue() || $urandom_range(0, 299) == 0;
         send_item(pick_sample(), fs, pick_addend());
      end
      req_valid <= 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      // directed: small frame with extremes, taps wider than the row, width shrink mid-row
      run_phase(4, 2, 2, 1, 20, 1);
      run_phase(3, 5, 1, 0, 6, 1);
      run_phase(10, 3, 2, 0, 15, 1);
      run_phase(4, 2, 2, 1, 12, 0);
      // random settings, clamped extremes included
      long_hold = 1;
      run_phase(8, 3, 3, 0, 120, 1);
      while (items_sent < 250) begin
         case ($urandom_range(0, 5))
            0: run_phase($urandom_range(0, 1) ? 11'd0 : 11'd2047,
                         $urandom_range(0, 1) ? 4'd0 : 4'd15,
                         $urandom_range(0, 1) ? 4'd0 : 4'd15,
                         1'($urandom_range(0, 1)), 40, 1);
            default: run_phase(11'($urandom_range(1, 24)), 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                               $urandom_range(20, 80), $urandom_range(0, 3) != 0);
         endcase
      end
      quiet = 1;
      run_phase(24, 8, 2, 1, 100, 1);
      run_phase(12, 4, 8, 1, 130, 1);
      wait_idle();
      $display("ran %0d phases, %0d items, %0d results checked",
               phases, items_sent, sb.checked);
      $display("covered clamped settings, width shrink, add mode and a long output hold-off");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("separable_2d_fir_filter_test: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("separable_2d_fir_filter_test: FAIL");
      end
      $finish;
   end
endmodule

// ===== separable_2d_fir_filter.f =====
hw/rtl/sfir_pkg.sv
hw/rtl/sfir_mac_cell.sv
hw/rtl/separable_2d_fir_filter.sv
bench/separable_2d_fir_filter_test.sv
